FILE: src/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared widths, item types and the arctangent table for the circle point
// generator pipeline.
// ----------------------------------------------------------------------------
package cpg_pkg;

    localparam int CNT_W   = 13;
    localparam int IDX_W   = 12;
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int PH_W    = 32;
    localparam int DIV_W   = 13;
    localparam int DIV_BITS = IDX_W + PH_W;
    localparam int XW      = 50;
    localparam int ZW      = 33;
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
    localparam logic [CNT_W-1:0] COUNT_RESET = 13'd101;

    typedef struct packed {
        logic                      ok;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          r;
        logic [DIV_W-1:0]          rem;
        logic [PH_W-1:0]           quot;
        logic [IDX_W-1:0]          dvd;
    } t_div_item;

    typedef struct packed {
        logic                      ok;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [XW-1:0]      x;
        logic signed [XW-1:0]      y;
        logic signed [ZW-1:0]      z;
        logic [1:0]                quad;
    } t_cor_item;

    function automatic logic signed [ZW-1:0] atan_turns(input int k);
        logic signed [ZW-1:0] v;
        case (k)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            24: v = 33'sd41;
            25: v = 33'sd20;
            26: v = 33'sd10;
            27: v = 33'sd5;
            28: v = 33'sd3;
            29: v = 33'sd1;
            30: v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/cpg_div_cell.sv
// ----------------------------------------------------------------------------
// cpg_div_cell
// One restoring division step: produces one phase quotient bit per cell.
// ----------------------------------------------------------------------------
module cpg_div_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [cpg_pkg::DIV_W-1:0]  i_divisor,
    input  logic                       i_valid,
    input  cpg_pkg::t_div_item         i_item,
    output logic                       o_valid,
    output cpg_pkg::t_div_item         o_item
);

    logic                     r_valid;
    cpg_pkg::t_div_item       r_item;
    cpg_pkg::t_div_item       n_item;
    logic [cpg_pkg::DIV_W:0]  trial;
    logic                     qbit;

    always_comb begin
        n_item = i_item;
        trial  = {i_item.rem, i_item.dvd[cpg_pkg::IDX_W-1]};
        qbit   = (trial >= {1'b0, i_divisor});
        if (qbit) begin
            n_item.rem = cpg_pkg::DIV_W'(trial - {1'b0, i_divisor});
        end else begin
            n_item.rem = trial[cpg_pkg::DIV_W-1:0];
        end
        n_item.quot = {i_item.quot[cpg_pkg::PH_W-2:0], qbit};
        n_item.dvd  = {i_item.dvd[cpg_pkg::IDX_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: src/cpg_cordic_cell.sv
// ----------------------------------------------------------------------------
// cpg_cordic_cell
// One rotation-mode CORDIC micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module cpg_cordic_cell #(
    parameter int K = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  cpg_pkg::t_cor_item i_item,
    output logic               o_valid,
    output cpg_pkg::t_cor_item o_item
);

    logic                              r_valid;
    cpg_pkg::t_cor_item                r_item;
    cpg_pkg::t_cor_item                n_item;
    logic signed [cpg_pkg::XW-1:0]     xs;
    logic signed [cpg_pkg::XW-1:0]     ys;

    always_comb begin
        n_item = i_item;
        xs = i_item.x >>> K;
        ys = i_item.y >>> K;
        if (!i_item.z[cpg_pkg::ZW-1]) begin
            n_item.x = i_item.x - ys;
            n_item.y = i_item.y + xs;
            n_item.z = i_item.z - cpg_pkg::atan_turns(K);
        end else begin
            n_item.x = i_item.x + ys;
            n_item.y = i_item.y - xs;
            n_item.z = i_item.z + cpg_pkg::atan_turns(K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: src/circle_polygon_point_generator_top.sv
// ----------------------------------------------------------------------------
// circle_polygon_point_generator_top
// Points on a circle polygon from a centre, radius and point index.
//
// Input channel (i_valid/o_ready) takes centre, radius and point index; the
// output channel (o_valid/i_ready) returns one point and an index flag per
// transaction, in order. The config channel (i_cfg_valid/o_cfg_ready) writes
// the point count; it is always ready. The user must see that it is written
// only while the block is idle; the block does not enforce it. The pipeline
// chains 44 divider cells (one phase bit each), one gain multiply stage,
// CORDIC_STAGES rotation cells and an output register, and accepts one
// transaction per cycle unless the output stalls. The whole chain advances
// together, so when the receiver stalls the output holds and o_ready drops
// until taken. Reset empties the pipeline and sets the point count to 101.
// ----------------------------------------------------------------------------
module circle_polygon_point_generator_top #(
    parameter int MAX_POINTS    = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cpg_pkg::CNT_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cpg_pkg::COORD_W-1:0]  i_centre_x,
    input  logic signed [cpg_pkg::COORD_W-1:0]  i_centre_y,
    input  logic [cpg_pkg::RAD_W-1:0]           i_radius,
    input  logic [cpg_pkg::IDX_W-1:0]           i_point_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cpg_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [cpg_pkg::COORD_W-1:0]  o_point_y,
    output logic                                o_index_valid
);

    localparam int NB = cpg_pkg::DIV_BITS;

    logic [cpg_pkg::CNT_W-1:0]  r_count;
    logic [cpg_pkg::CNT_W-1:0]  eff_n;
    logic [cpg_pkg::DIV_W-1:0]  divisor;
    logic                       adv;

    cpg_pkg::t_div_item div_item [0:NB];
    logic               div_vld  [0:NB];
    cpg_pkg::t_cor_item cor_item [0:CORDIC_STAGES];
    logic               cor_vld  [0:CORDIC_STAGES];

    logic                       r_mul_valid;
    cpg_pkg::t_cor_item         r_mul_item;
    logic [62:0]                prod;

    logic                                r_out_valid;
    logic signed [cpg_pkg::COORD_W-1:0]  r_px;
    logic signed [cpg_pkg::COORD_W-1:0]  r_py;
    logic                                r_ok;
    logic signed [cpg_pkg::COORD_W-1:0]  n_px;
    logic signed [cpg_pkg::COORD_W-1:0]  n_py;
    logic signed [cpg_pkg::XW-1:0]       c_v;
    logic signed [cpg_pkg::XW-1:0]       s_v;
    logic signed [cpg_pkg::XW-1:0]       c_rnd;
    logic signed [cpg_pkg::XW-1:0]       s_rnd;
    logic signed [cpg_pkg::XW-1:0]       sum_x;
    logic signed [cpg_pkg::XW-1:0]       sum_y;

    function automatic logic signed [cpg_pkg::COORD_W-1:0] sat32(
        input logic signed [cpg_pkg::XW-1:0] v
    );
        logic signed [cpg_pkg::XW-1:0] hi;
        logic signed [cpg_pkg::XW-1:0] lo;
        hi = cpg_pkg::XW'(64'sh7FFFFFFF);
        lo = -cpg_pkg::XW'(64'sh80000000);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[cpg_pkg::COORD_W-1:0];
    endfunction

    // point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= cpg_pkg::COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (32'(r_count) > MAX_POINTS) begin
            eff_n = cpg_pkg::CNT_W'(MAX_POINTS);
        end else begin
            eff_n = r_count;
        end
        if (eff_n >= cpg_pkg::CNT_W'(2)) begin
            divisor = cpg_pkg::DIV_W'(eff_n - cpg_pkg::CNT_W'(1));
        end else begin
            divisor = cpg_pkg::DIV_W'(1);
        end
    end

    assign adv     = !r_out_valid || i_ready;
    assign o_ready = adv;

    // chain entry
    always_comb begin
        div_vld[0]       = i_valid;
        div_item[0].ok   = ({1'b0, i_point_index} < eff_n);
        div_item[0].cx   = i_centre_x;
        div_item[0].cy   = i_centre_y;
        div_item[0].r    = i_radius;
        div_item[0].rem  = '0;
        div_item[0].quot = '0;
        div_item[0].dvd  = i_point_index;
    end

    for (genvar g = 0; g < NB; g++) begin : g_div
        cpg_div_cell u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_divisor (divisor),
            .i_valid   (div_vld[g]),
            .i_item    (div_item[g]),
            .o_valid   (div_vld[g+1]),
            .o_item    (div_item[g+1])
        );
    end

    // gain multiply
    assign prod = 63'(div_item[NB].r) * 63'(cpg_pkg::GAIN_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (adv) begin
            r_mul_valid <= div_vld[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mul_item.ok   <= div_item[NB].ok;
            r_mul_item.cx   <= div_item[NB].cx;
            r_mul_item.cy   <= div_item[NB].cy;
            r_mul_item.x    <= cpg_pkg::XW'(prod[62:16]);
            r_mul_item.y    <= '0;
            r_mul_item.z    <= cpg_pkg::ZW'(div_item[NB].quot[cpg_pkg::PH_W-3:0]);
            r_mul_item.quad <= div_item[NB].quot[cpg_pkg::PH_W-1:cpg_pkg::PH_W-2];
        end
    end

    assign cor_vld[0]  = r_mul_valid;
    assign cor_item[0] = r_mul_item;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
        cpg_cordic_cell #(.K(k)) u_cor (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (cor_vld[k]),
            .i_item  (cor_item[k]),
            .o_valid (cor_vld[k+1]),
            .o_item  (cor_item[k+1])
        );
    end

    // quadrant fold, round, add centre, saturate; zero for an invalid index
    always_comb begin
        case (cor_item[CORDIC_STAGES].quad)
            2'd0: begin
                c_v = cor_item[CORDIC_STAGES].x;
                s_v = cor_item[CORDIC_STAGES].y;
            end
            2'd1: begin
                c_v = -cor_item[CORDIC_STAGES].y;
                s_v = cor_item[CORDIC_STAGES].x;
            end
            2'd2: begin
                c_v = -cor_item[CORDIC_STAGES].x;
                s_v = -cor_item[CORDIC_STAGES].y;
            end
            default: begin
                c_v = cor_item[CORDIC_STAGES].y;
                s_v = -cor_item[CORDIC_STAGES].x;
            end
        endcase
        c_rnd = (c_v + cpg_pkg::XW'(32768)) >>> 16;
        s_rnd = (s_v + cpg_pkg::XW'(32768)) >>> 16;
        sum_x = cpg_pkg::XW'(cor_item[CORDIC_STAGES].cx) + c_rnd;
        sum_y = cpg_pkg::XW'(cor_item[CORDIC_STAGES].cy) + s_rnd;
        if (cor_item[CORDIC_STAGES].ok) begin
            n_px = sat32(sum_x);
            n_py = sat32(sum_y);
        end else begin
            n_px = '0;
            n_py = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= cor_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px <= n_px;
            r_py <= n_py;
            r_ok <= cor_item[CORDIC_STAGES].ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_index_valid = r_ok;

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_index_valid) |-> (o_point_x == 0 && o_point_y == 0))
        else $error("invalid index with nonzero point");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> (!o_ready ##1 o_valid))
        else $error("stalled result lost or input taken during stall");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the circle polygon point generator against an in-bench CORDIC
// point predictor, with random stalls on both sides and point count changes.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        r;
        logic [11:0]        idx;
    } t_job;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               ok;
    } t_point;

    localparam int LATENCY = 62;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [cpg_pkg::CNT_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_job in_job = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic out_ok;

    t_job   pending_jobs[$];
    t_point expected_points[$];
    logic [cpg_pkg::CNT_W-1:0] model_count = cpg_pkg::COUNT_RESET;
    int mismatches = 0;
    int accepted = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int gap_left = 0;
    int stall_left = 0;

    circle_polygon_point_generator_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_centre_x(in_job.cx), .i_centre_y(in_job.cy),
        .i_radius(in_job.r), .i_point_index(in_job.idx),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_point_x(out_x), .o_point_y(out_y), .o_index_valid(out_ok)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_point circle_point(t_job j, logic [cpg_pkg::CNT_W-1:0] cnt);
        t_point p;
        longint n, d, x, y, z, c, s, xs, ys;
        logic [63:0] ph;
        logic [1:0] q;
        longint turns[16] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861};
        p = '0;
        n = longint'(cnt);
        if (n > 4096) n = 4096;
        if (longint'(j.idx) >= n) return p;
        d = (n >= 2) ? n - 1 : 1;
        ph = ({20'd0, j.idx, 32'd0} / d) & 64'hFFFFFFFF;
        q = ph[31:30];
        z = longint'(ph[29:0]);
        x = longint'((64'(j.r) * 64'h9B74EDA8) >> 16);
        y = 0;
        for (int k = 0; k < 16; k++) begin
            xs = fshr(x, k);
            ys = fshr(y, k);
            if (z >= 0) begin
                x -= ys; y += xs; z -= turns[k];
            end else begin
                x += ys; y -= xs; z += turns[k];
            end
        end
        case (q)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        p.px = clamp32(longint'(j.cx) + fshr(c + 32768, 16));
        p.py = clamp32(longint'(j.cy) + fshr(s + 32768, 16));
        p.ok = 1'b1;
        return p;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF - $urandom_range(0, 1000000);
            1: return 32'h80000000 + $urandom_range(0, 1000000);
            2: return $urandom_range(0, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_job rnd_job(logic [cpg_pkg::CNT_W-1:0] cnt);
        t_job j;
        int top;
        j.cx = rnd_coord();
        j.cy = rnd_coord();
        case ($urandom_range(0, 3))
            0: j.r = 31'(32'h7FFFFFFF - $urandom_range(0, 1000));
            1: j.r = 31'($urandom_range(0, 65536 * 16));
            default: j.r = 31'($urandom);
        endcase
        top = (int'(cnt) > 4096) ? 4095 : int'(cnt);
        if ($urandom_range(0, 9) == 0) j.idx = 12'($urandom);
        else j.idx = 12'($urandom_range(0, top > 0 ? top : 0));
        return j;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_ready) begin
        end else begin
            if (in_valid) begin
                expected_points.push_back(circle_point(in_job, model_count));
                accepted++;
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_jobs.size() > 0) begin
                in_job <= pending_jobs.pop_front();
                in_valid <= 1'b1;
                gap_left = gap_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_point e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction x=%h", out_x);
            end else begin
                e = expected_points.pop_front();
                if (e.px !== out_x || e.py !== out_y || e.ok !== out_ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%h y=%h ok=%b got x=%h y=%h ok=%b",
                                 e.px, e.py, e.ok, out_x, out_y, out_ok);
                end
            end
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && accepted > 600) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            stall_left = gap_len();
            out_ready <= 1'b1;
        end
    end

    task automatic write_count(logic [cpg_pkg::CNT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        model_count = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int n_items);
        for (int i = 0; i < n_items; i++) pending_jobs.push_back(rnd_job(model_count));
        while (pending_jobs.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial begin
        t_job j;
        logic [cpg_pkg::CNT_W-1:0] counts[8] = '{13'd101, 13'd2, 13'd1, 13'd0,
                                                 13'd8191, 13'd4096, 13'd4097,
                                                 13'd7};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // directed: field extremes, closing point, out-of-range index
        j = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 12'd0};
        pending_jobs.push_back(j);
        j = '{32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 12'd50};
        pending_jobs.push_back(j);
        j = '{32'sd0, 32'sd0, 31'd0, 12'd100};
        pending_jobs.push_back(j);
        j = '{32'sd0, 32'sd0, 31'h10000, 12'd101};
        pending_jobs.push_back(j);
        j = '{32'sd0, 32'sd0, 31'h10000, 12'd4095};
        pending_jobs.push_back(j);
        for (int i = 0; i < 8; i++) begin
            j = '{32'sd65536, -32'sd65536, 31'h40000, 12'(i * 13)};
            pending_jobs.push_back(j);
        end
        run_phase(400);
        for (int p = 1; p < 8; p++) begin
            write_count(counts[p]);
            j = '{32'sd0, 32'sd0, 31'h7FFFFFFF, 12'd0};
            pending_jobs.push_back(j);
            j.idx = 12'hFFF;
            pending_jobs.push_back(j);
            j.idx = 12'd1;
            pending_jobs.push_back(j);
            run_phase(p == 7 ? 200 : 130);
        end
        write_count(13'($urandom_range(2, 4096)));
        run_phase(200);
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

FILE: files.f
src/cpg_pkg.sv
src/cpg_div_cell.sv
src/cpg_cordic_cell.sv
src/circle_polygon_point_generator_top.sv
test/testbench.sv
